[design/ip_flow_tuple_extractor_assert.svh]
// Assertion macros for the flow tuple extractor.
`ifndef IP_FLOW_TUPLE_EXTRACTOR_ASSERT_SVH
`define IP_FLOW_TUPLE_EXTRACTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define IPFT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IPFT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IPFT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define IPFT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[design/ipft_pkg.sv]
`timescale 1ns / 1ps

package ipft_pkg;

  localparam int OFFSET_W = 17;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_FRAGMENT   = 8'd44;
  localparam logic [7:0] NH_AH         = 8'd51;
  localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
  localparam logic [7:0] NH_MOBILITY   = 8'd135;
  localparam logic [7:0] NH_HIP        = 8'd139;
  localparam logic [7:0] NH_SHIM6      = 8'd140;
  localparam logic [7:0] NH_TEST1      = 8'd253;
  localparam logic [7:0] NH_TEST2      = 8'd254;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [OFFSET_W-1:0] V4_MIN_LEN  = 17'd20;
  localparam logic [OFFSET_W-1:0] V6_HDR_LEN  = 17'd40;

  typedef enum logic [2:0] {
    PH_START,
    PH_V4,
    PH_V6_FIXED,
    PH_V6_WAIT,
    PH_V6_LEN8,
    PH_V6_LENAH,
    PH_V6_DONE,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_VERSION,
    ST_TRUNCATED
  } status_t;

  typedef enum logic [1:0] {
    EXT_NONE,
    EXT_LEN8,
    EXT_FRAG,
    EXT_AH
  } ext_kind_t;

  function automatic ext_kind_t ext_kind(input logic [7:0] t);
    ext_kind_t k;
    unique case (t)
      NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_MOBILITY, NH_HIP, NH_SHIM6,
      NH_TEST1, NH_TEST2: k = EXT_LEN8;
      NH_FRAGMENT:        k = EXT_FRAG;
      NH_AH:              k = EXT_AH;
      default:            k = EXT_NONE;
    endcase
    return k;
  endfunction

endpackage

[design/ip_flow_tuple_extractor.sv]
`timescale 1ns / 1ps

// Extracts the flow tuple (protocol, UE and peer addresses, TCP/UDP ports,
// packet length) from an IPv4 or IPv6 packet streamed one byte per item,
// walking the IPv6 extension header chain on the fly. A new byte is taken
// every cycle unless a last byte is waiting; each byte passes through an
// input register, one pass of offset-compare and capture logic, and, on the
// byte marked tlast, lands in the result register, from which the result is
// offered. Bytes that are not last never wait on the result side; a last
// byte waits in the input register only while the previous result has not
// been taken. Status travels in m_tuser: ok, unknown IP version, or truncated
// (packet ended before the headers and ports were complete).

module ip_flow_tuple_extractor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // data_byte[7:0], session_id[71:8]
  input  logic         s_tlast,   // last_byte
  input  logic         s_tuser,   // uplink
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [383:0] m_tdata,   // ip_version[3:0], protocol[11:4],
                                  // ue_addr_high[75:12], ue_addr_low[139:76],
                                  // peer_addr_high[203:140], peer_addr_low[267:204],
                                  // ue_port[283:268], peer_port[299:284],
                                  // packet_length[316:300], session_out[380:317],
                                  // zero fill[383:381]
  output logic [1:0]   m_tuser    // status[1:0]
);
  import ipft_pkg::*;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        in_uplink;
  logic [63:0] in_session;

  // parse state
  phase_t                phase, phase_next;
  logic [OFFSET_W-1:0]   byte_offset, byte_offset_next;
  logic [7:0]            next_header, next_header_next;
  logic [OFFSET_W-1:0]   header_end, header_end_next;
  logic [OFFSET_W-1:0]   payload_end, payload_end_next;
  logic [63:0]           src_addr_hi, src_addr_hi_next;
  logic [63:0]           src_addr_lo, src_addr_lo_next;
  logic [63:0]           dst_addr_hi, dst_addr_hi_next;
  logic [63:0]           dst_addr_lo, dst_addr_lo_next;
  logic [15:0]           sport, sport_next;
  logic [15:0]           dport, dport_next;
  logic [OFFSET_W-1:0]   length_value, length_value_next;
  logic [3:0]            version_seen, version_seen_next;
  logic                  direction, direction_next;
  logic [63:0]           session, session_next;

  // result register
  status_t               out_status, out_status_next;
  logic [3:0]            out_version, out_version_next;
  logic [7:0]            out_protocol, out_protocol_next;
  logic [63:0]           out_ue_hi, out_ue_hi_next;
  logic [63:0]           out_ue_lo, out_ue_lo_next;
  logic [63:0]           out_peer_hi, out_peer_hi_next;
  logic [63:0]           out_peer_lo, out_peer_lo_next;
  logic [15:0]           out_ue_port, out_ue_port_next;
  logic [15:0]           out_peer_port, out_peer_port_next;
  logic [OFFSET_W-1:0]   out_length, out_length_next;
  logic [63:0]           out_session, out_session_next;

  logic                  out_free;
  logic                  fire;
  logic [OFFSET_W-1:0]   off;
  logic                  capture;
  logic [OFFSET_W:0]     count;
  logic                  l4;
  logic [OFFSET_W-1:0]   port_idx;
  ext_kind_t             kind;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_byte    <= s_tdata[7:0];
      in_session <= s_tdata[71:8];
      in_last    <= s_tlast;
      in_uplink  <= s_tuser;
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_offset_next  = byte_offset;
    next_header_next  = next_header;
    header_end_next   = header_end;
    payload_end_next  = payload_end;
    src_addr_hi_next  = src_addr_hi;
    src_addr_lo_next  = src_addr_lo;
    dst_addr_hi_next  = dst_addr_hi;
    dst_addr_lo_next  = dst_addr_lo;
    sport_next        = sport;
    dport_next        = dport;
    length_value_next = length_value;
    version_seen_next = version_seen;
    direction_next    = direction;
    session_next      = session;
    capture           = 1'b0;
    kind              = EXT_NONE;
    port_idx          = '0;

    off = (phase == PH_START) ? '0 : byte_offset;

    if (phase == PH_START) begin
      next_header_next  = '0;
      header_end_next   = '0;
      payload_end_next  = '0;
      src_addr_hi_next  = '0;
      src_addr_lo_next  = '0;
      dst_addr_hi_next  = '0;
      dst_addr_lo_next  = '0;
      sport_next        = '0;
      dport_next        = '0;
      length_value_next = '0;
      direction_next    = in_uplink;
      session_next      = in_session;
      version_seen_next = in_byte[7:4];
      if (in_byte[7:4] == VER_IPV4) begin
        phase_next      = PH_V4;
        header_end_next = {{(OFFSET_W-6){1'b0}}, in_byte[3:0], 2'b00};
      end else if (in_byte[7:4] == VER_IPV6) begin
        phase_next = PH_V6_FIXED;
      end else begin
        phase_next = PH_BAD;
      end
    end

    if (phase_next == PH_V4) begin
      if (off == 17'd2 || off == 17'd3)
        length_value_next = {length_value_next[OFFSET_W-9:0], in_byte};
      if (off == 17'd9) next_header_next = in_byte;
      if (off >= 17'd12 && off < 17'd16)
        src_addr_lo_next = {src_addr_lo_next[55:0], in_byte};
      if (off >= 17'd16 && off < 17'd20)
        dst_addr_lo_next = {dst_addr_lo_next[55:0], in_byte};
      capture = 1'b1;
    end else if (phase_next == PH_V6_FIXED) begin
      if (off == 17'd4 || off == 17'd5)
        payload_end_next = {payload_end_next[OFFSET_W-9:0], in_byte};
      if (off == 17'd5) begin
        payload_end_next  = payload_end_next + V6_HDR_LEN;
        length_value_next = payload_end_next;
      end
      if (off == 17'd6) next_header_next = in_byte;
      if (off >= 17'd8 && off < 17'd16)
        src_addr_hi_next = {src_addr_hi_next[55:0], in_byte};
      if (off >= 17'd16 && off < 17'd24)
        src_addr_lo_next = {src_addr_lo_next[55:0], in_byte};
      if (off >= 17'd24 && off < 17'd32)
        dst_addr_hi_next = {dst_addr_hi_next[55:0], in_byte};
      if (off >= 17'd32 && off < 17'd40)
        dst_addr_lo_next = {dst_addr_lo_next[55:0], in_byte};
      if (off == 17'd39) begin
        header_end_next = V6_HDR_LEN;
        phase_next = (header_end_next >= payload_end_next ||
                      ext_kind(next_header_next) == EXT_NONE) ? PH_V6_DONE : PH_V6_WAIT;
      end
    end else if (phase_next == PH_V6_WAIT) begin
      if (off == header_end) begin
        kind = ext_kind(next_header);
        next_header_next = in_byte;
        if (kind == EXT_FRAG) begin
          header_end_next = header_end + 17'd8;
          phase_next = (header_end_next >= payload_end ||
                        ext_kind(in_byte) == EXT_NONE) ? PH_V6_DONE : PH_V6_WAIT;
        end else begin
          phase_next = (kind == EXT_AH) ? PH_V6_LENAH : PH_V6_LEN8;
        end
      end
    end else if (phase_next == PH_V6_LEN8) begin
      header_end_next = header_end + {6'd0, in_byte, 3'b000} + 17'd8;
      phase_next = (header_end_next >= payload_end ||
                    ext_kind(next_header) == EXT_NONE) ? PH_V6_DONE : PH_V6_WAIT;
    end else if (phase_next == PH_V6_LENAH) begin
      header_end_next = header_end + {6'd0, ({1'b0, in_byte} + 9'd2), 2'b00};
      phase_next = (header_end_next >= payload_end ||
                    ext_kind(next_header) == EXT_NONE) ? PH_V6_DONE : PH_V6_WAIT;
    end else if (phase_next == PH_V6_DONE) begin
      capture = 1'b1;
    end

    if (capture && off >= header_end_next &&
        {1'b0, off} < ({1'b0, header_end_next} + 18'd4)) begin
      port_idx = off - header_end_next;
      if (port_idx[OFFSET_W-1:1] == '0) sport_next = {sport_next[7:0], in_byte};
      else                               dport_next = {dport_next[7:0], in_byte};
    end

    count = {1'b0, off} + 18'd1;
    l4    = (next_header_next == PROTO_TCP) || (next_header_next == PROTO_UDP);

    priority if (phase_next == PH_BAD) begin
      out_status_next = ST_BAD_VERSION;
    end else if (phase_next == PH_V4) begin
      out_status_next = (count < {1'b0, V4_MIN_LEN} ||
                         (l4 && count < ({1'b0, header_end_next} + 18'd4))) ?
                        ST_TRUNCATED : ST_OK;
    end else begin
      out_status_next = (count < {1'b0, V6_HDR_LEN} || phase_next != PH_V6_DONE ||
                         (l4 && count < ({1'b0, header_end_next} + 18'd4))) ?
                        ST_TRUNCATED : ST_OK;
    end

    out_version_next   = version_seen_next;
    out_session_next   = session_next;
    out_protocol_next  = '0;
    out_ue_hi_next     = '0;
    out_ue_lo_next     = '0;
    out_peer_hi_next   = '0;
    out_peer_lo_next   = '0;
    out_ue_port_next   = '0;
    out_peer_port_next = '0;
    out_length_next    = '0;
    if (out_status_next == ST_OK) begin
      out_protocol_next = next_header_next;
      out_ue_hi_next    = direction_next ? src_addr_hi_next : dst_addr_hi_next;
      out_ue_lo_next    = direction_next ? src_addr_lo_next : dst_addr_lo_next;
      out_peer_hi_next  = direction_next ? dst_addr_hi_next : src_addr_hi_next;
      out_peer_lo_next  = direction_next ? dst_addr_lo_next : src_addr_lo_next;
      if (l4) begin
        out_ue_port_next   = direction_next ? sport_next : dport_next;
        out_peer_port_next = direction_next ? dport_next : sport_next;
      end
      out_length_next = length_value_next;
    end

    if (in_last) begin
      phase_next       = PH_START;
      byte_offset_next = '0;
    end else begin
      byte_offset_next = (off < OFFSET_MAX) ? off + 17'd1 : off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      byte_offset <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      byte_offset <= byte_offset_next;
    end
    if (fire) begin
      next_header  <= next_header_next;
      header_end   <= header_end_next;
      payload_end  <= payload_end_next;
      src_addr_hi  <= src_addr_hi_next;
      src_addr_lo  <= src_addr_lo_next;
      dst_addr_hi  <= dst_addr_hi_next;
      dst_addr_lo  <= dst_addr_lo_next;
      sport        <= sport_next;
      dport        <= dport_next;
      length_value <= length_value_next;
      version_seen <= version_seen_next;
      direction    <= direction_next;
      session      <= session_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fire && in_last;
    end
    if (fire && in_last) begin
      out_status    <= out_status_next;
      out_version   <= out_version_next;
      out_protocol  <= out_protocol_next;
      out_ue_hi     <= out_ue_hi_next;
      out_ue_lo     <= out_ue_lo_next;
      out_peer_hi   <= out_peer_hi_next;
      out_peer_lo   <= out_peer_lo_next;
      out_ue_port   <= out_ue_port_next;
      out_peer_port <= out_peer_port_next;
      out_length    <= out_length_next;
      out_session   <= out_session_next;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_session, out_length, out_peer_port, out_ue_port,
                    out_peer_lo, out_peer_hi, out_ue_lo, out_ue_hi,
                    out_protocol, out_version};

`include "ip_flow_tuple_extractor_assert.svh"

  `IPFT_ASSERT_NXT(a_last_gives_result, clk, rst, fire && in_last, m_tvalid, "last byte gave no result")
  `IPFT_ASSERT_NXT(a_last_rearms, clk, rst, fire && in_last, phase == PH_START && byte_offset == '0, "parser not rearmed after last byte")
  `IPFT_ASSERT_IMP(a_wait_inside_payload, clk, rst, phase == PH_V6_WAIT, header_end < payload_end, "chain walk beyond payload end")
  `IPFT_ASSERT_IMP(a_status_code, clk, rst, m_tvalid, m_tuser == ST_OK || m_tuser == ST_BAD_VERSION || m_tuser == ST_TRUNCATED, "undefined status code")

endmodule

[dv/ip_flow_tuple_check.sv]
`timescale 1ns / 1ps

module ip_flow_tuple_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,   // data_byte[7:0], session_id[71:8]
  input  logic         s_tlast,   // last_byte
  input  logic         s_tuser,   // uplink
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [383:0] m_tdata,   // ip_version, protocol, ue_addr_high, ue_addr_low,
                                  // peer_addr_high, peer_addr_low, ue_port, peer_port,
                                  // packet_length, session_out, zero fill
  input  logic [1:0]   m_tuser,   // status
  output int           errors,
  output int           outstanding,
  output int           n_ok,
  output int           n_bad_ver,
  output int           n_trunc
);
  import ipft_pkg::*;

  localparam int unsigned OFS_MASK = OFFSET_MAX;

  typedef struct packed {
    status_t     status;
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [63:0] ue_hi;
    logic [63:0] ue_lo;
    logic [63:0] peer_hi;
    logic [63:0] peer_lo;
    logic [15:0] ue_port;
    logic [15:0] peer_port;
    logic [16:0] plen;
    logic [63:0] sess;
  } flow_tuple_t;

  flow_tuple_t awaited[$];

  int unsigned pos;
  phase_t      ph;
  logic [7:0]  nh;
  int unsigned hend;
  int unsigned pend;
  logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
  logic [15:0] sport, dport;
  logic [16:0] tot_len;
  logic [3:0]  ver;
  logic        up_q;
  logic [63:0] sess_q;

  function automatic ext_kind_t hdr_class(input logic [7:0] t);
    case (t)
      NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_MOBILITY, NH_HIP, NH_SHIM6,
      NH_TEST1, NH_TEST2: return EXT_LEN8;
      NH_FRAGMENT:        return EXT_FRAG;
      NH_AH:              return EXT_AH;
      default:            return EXT_NONE;
    endcase
  endfunction

  function automatic void clear_tuple();
    nh = '0;
    hend = 0;
    pend = 0;
    src_hi = '0;
    src_lo = '0;
    dst_hi = '0;
    dst_lo = '0;
    sport = '0;
    dport = '0;
    tot_len = '0;
    ver = '0;
  endfunction

  function automatic void settle_chain();
    if (hend >= pend || hdr_class(nh) == EXT_NONE) ph = PH_V6_DONE;
    else ph = PH_V6_WAIT;
  endfunction

  function automatic void grab_port(input int unsigned o, input logic [7:0] b);
    if (o >= hend && o < hend + 4) begin
      if (o - hend < 2) sport = {sport[7:0], b};
      else dport = {dport[7:0], b};
    end
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last, input logic up,
                            input logic [63:0] sid);
    int unsigned o;
    int unsigned n;
    ext_kind_t   k;
    logic        l4;
    flow_tuple_t t;
    o = (ph == PH_START) ? 0 : pos;
    if (ph == PH_START) begin
      clear_tuple();
      up_q = up;
      sess_q = sid;
      ver = b[7:4];
      if (ver == VER_IPV4) begin
        ph = PH_V4;
        hend = int'(b[3:0]) * 4;
      end else if (ver == VER_IPV6) begin
        ph = PH_V6_FIXED;
      end else begin
        ph = PH_BAD;
      end
    end
    case (ph)
      PH_V4: begin
        if (o == 2 || o == 3) tot_len = {tot_len[8:0], b};
        if (o == 9) nh = b;
        if (o >= 12 && o < 16) src_lo = {src_lo[55:0], b};
        if (o >= 16 && o < 20) dst_lo = {dst_lo[55:0], b};
        grab_port(o, b);
      end
      PH_V6_FIXED: begin
        if (o == 4 || o == 5) pend = ((pend << 8) | b) & OFS_MASK;
        if (o == 5) begin
          pend = pend + 40;
          tot_len = pend[16:0];
        end
        if (o == 6) nh = b;
        if (o >= 8 && o < 16) src_hi = {src_hi[55:0], b};
        if (o >= 16 && o < 24) src_lo = {src_lo[55:0], b};
        if (o >= 24 && o < 32) dst_hi = {dst_hi[55:0], b};
        if (o >= 32 && o < 40) dst_lo = {dst_lo[55:0], b};
        if (o == 39) begin
          hend = 40;
          settle_chain();
        end
      end
      PH_V6_WAIT: begin
        if (o == hend) begin
          k = hdr_class(nh);
          nh = b;
          if (k == EXT_FRAG) begin
            hend = hend + 8;
            settle_chain();
          end else begin
            ph = (k == EXT_AH) ? PH_V6_LENAH : PH_V6_LEN8;
          end
        end
      end
      PH_V6_LEN8: begin
        hend = (hend + int'(b) * 8 + 8) & OFS_MASK;
        settle_chain();
      end
      PH_V6_LENAH: begin
        hend = (hend + (int'(b) + 2) * 4) & OFS_MASK;
        settle_chain();
      end
      PH_V6_DONE: grab_port(o, b);
      default: ;
    endcase

    if (!last) begin
      pos = (o < OFS_MASK) ? o + 1 : o;
    end else begin
      n = o + 1;
      l4 = (nh == PROTO_TCP) || (nh == PROTO_UDP);
      t = '0;
      t.status = ST_OK;
      if (ph == PH_BAD) begin
        t.status = ST_BAD_VERSION;
      end else if (ph == PH_V4) begin
        if (n < V4_MIN_LEN || (l4 && n < hend + 4)) t.status = ST_TRUNCATED;
      end else if (n < V6_HDR_LEN || ph != PH_V6_DONE || (l4 && n < hend + 4)) begin
        t.status = ST_TRUNCATED;
      end
      t.ver = ver;
      t.sess = sess_q;
      if (t.status == ST_OK) begin
        t.proto = nh;
        t.ue_hi = up_q ? src_hi : dst_hi;
        t.ue_lo = up_q ? src_lo : dst_lo;
        t.peer_hi = up_q ? dst_hi : src_hi;
        t.peer_lo = up_q ? dst_lo : src_lo;
        if (l4) begin
          t.ue_port = up_q ? sport : dport;
          t.peer_port = up_q ? dport : sport;
        end
        t.plen = tot_len;
      end
      case (t.status)
        ST_OK:          n_ok++;
        ST_BAD_VERSION: n_bad_ver++;
        default:        n_trunc++;
      endcase
      awaited.push_back(t);
      ph = PH_START;
      pos = 0;
    end
  endtask

  function automatic int field_diff(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic compare_tuple();
    flow_tuple_t w;
    int bad;
    if (awaited.size() == 0) begin
      $error("result with no packet outstanding: status %0d", m_tuser);
      errors++;
    end else begin
      w = awaited.pop_front();
      bad = 0;
      bad += field_diff("status", w.status, m_tuser);
      bad += field_diff("ip_version", w.ver, m_tdata[3:0]);
      bad += field_diff("protocol", w.proto, m_tdata[11:4]);
      bad += field_diff("ue_addr_high", w.ue_hi, m_tdata[75:12]);
      bad += field_diff("ue_addr_low", w.ue_lo, m_tdata[139:76]);
      bad += field_diff("peer_addr_high", w.peer_hi, m_tdata[203:140]);
      bad += field_diff("peer_addr_low", w.peer_lo, m_tdata[267:204]);
      bad += field_diff("ue_port", w.ue_port, m_tdata[283:268]);
      bad += field_diff("peer_port", w.peer_port, m_tdata[299:284]);
      bad += field_diff("packet_length", w.plen, m_tdata[316:300]);
      bad += field_diff("session_out", w.sess, m_tdata[380:317]);
      errors += bad;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph = PH_START;
      pos = 0;
      clear_tuple();
      up_q = 1'b0;
      sess_q = '0;
      awaited.delete();
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata[7:0], s_tlast, s_tuser, s_tdata[71:8]);
      if (m_tvalid && m_tready) compare_tuple();
    end
    outstanding = awaited.size();
  end

endmodule

[dv/ip_flow_tuple_extractor_test.sv]
`timescale 1ns / 1ps

module ip_flow_tuple_extractor_test;
  import ipft_pkg::*;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;   // data_byte[7:0], session_id[71:8]
  logic         s_tlast;   // last_byte
  logic         s_tuser;   // uplink
  logic         m_tvalid;
  logic         m_tready;
  logic [383:0] m_tdata;   // ip_version .. session_out, see checker
  logic [1:0]   m_tuser;   // status

  int fail_count;
  int outstanding;
  int n_ok;
  int n_bad_ver;
  int n_trunc;

  logic [7:0] pkt[$];
  logic [7:0] ext_plan[$];
  logic [7:0] ext_types[10] = '{NH_HOP_BY_HOP, NH_ROUTING, NH_FRAGMENT, NH_AH,
                                NH_DEST_OPTS, NH_MOBILITY, NH_HIP, NH_SHIM6,
                                NH_TEST1, NH_TEST2};
  int  fill_mode;
  bit  calm;
  bit  hold_go;
  bit  offer_held;
  int  n_pkts;
  int  n_bytes;

  always #2 clk = ~clk;

  ip_flow_tuple_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ip_flow_tuple_check tuple_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (fail_count),
    .outstanding (outstanding),
    .n_ok        (n_ok),
    .n_bad_ver   (n_bad_ver),
    .n_trunc     (n_trunc)
  );

  function automatic logic [7:0] rb();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] addr_byte();
    if (fill_mode == 1) return 8'h00;
    if (fill_mode == 2) return 8'hFF;
    return rb();
  endfunction

  function automatic logic [7:0] pick_ext();
    return ext_types[$urandom_range(9)];
  endfunction

  function automatic logic [7:0] pick_upper();
    int r;
    r = $urandom_range(9);
    if (r < 4) return PROTO_TCP;
    if (r < 8) return PROTO_UDP;
    return rb();
  endfunction

  function automatic void v4_packet(input logic [3:0] ihl, input logic [7:0] proto,
                                    input int tail, input int len_field);
    int lenv;
    pkt.delete();
    pkt.push_back({VER_IPV4, ihl});
    pkt.push_back(rb());
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    repeat (5) pkt.push_back(rb());
    pkt.push_back(proto);
    repeat (2) pkt.push_back(rb());
    repeat (8) pkt.push_back(addr_byte());
    for (int i = 5; i < ihl; i++) repeat (4) pkt.push_back(rb());
    repeat (tail) pkt.push_back(rb());
    lenv = (len_field < 0) ? pkt.size() : len_field;
    pkt[2] = lenv[15:8];
    pkt[3] = lenv[7:0];
  endfunction

  function automatic void v6_packet(input logic [7:0] upper, input int tail,
                                    input int len_field);
    int lenv;
    int link;
    int hl;
    logic [7:0] tclass;
    pkt.delete();
    tclass = rb();
    pkt.push_back({VER_IPV6, tclass[3:0]});
    repeat (3) pkt.push_back(rb());
    repeat (3) pkt.push_back(8'h00);
    pkt.push_back(rb());
    repeat (32) pkt.push_back(addr_byte());
    link = 6;
    foreach (ext_plan[j]) begin
      pkt[link] = ext_plan[j];
      link = pkt.size();
      pkt.push_back(8'h00);
      if (ext_plan[j] == NH_FRAGMENT) begin
        repeat (7) pkt.push_back(rb());
      end else if (ext_plan[j] == NH_AH) begin
        hl = $urandom_range(3);
        pkt.push_back(hl[7:0]);
        repeat ((hl + 2) * 4 - 2) pkt.push_back(rb());
      end else begin
        hl = $urandom_range(2);
        pkt.push_back(hl[7:0]);
        repeat (hl * 8 + 6) pkt.push_back(rb());
      end
    end
    pkt[link] = upper;
    repeat (tail) pkt.push_back(rb());
    lenv = (len_field < 0) ? pkt.size() - 40 : len_field;
    pkt[4] = lenv[15:8];
    pkt[5] = lenv[7:0];
  endfunction

  function automatic void junk_packet(input logic [7:0] first, input int n);
    pkt.delete();
    pkt.push_back(first);
    repeat (n - 1) pkt.push_back(rb());
  endfunction

  function automatic void cut(input int n);
    pkt = pkt[0:n-1];
  endfunction

  task automatic send_packet(input logic up, input logic [63:0] sess);
    int i;
    i = 0;
    while (i < pkt.size()) begin
      @(posedge clk);
      if (!offer_held && !calm && $urandom_range(99) < 23) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= {sess, pkt[i]};
        s_tlast  <= (i == pkt.size() - 1);
        s_tuser  <= up;
      end
      @(negedge clk);
      offer_held = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) i++;
    end
    n_pkts++;
    n_bytes += pkt.size();
  endtask

  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    int sel;
    int r_idx;
    logic [3:0] v;
    logic [7:0] first;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = 1'b0;
    calm = 0;
    hold_go = 0;
    offer_held = 0;
    fill_mode = 0;
    n_pkts = 0;
    n_bytes = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    fill_mode = 2;
    v4_packet(4'd5, PROTO_TCP, 8, 16'hFFFF);
    send_packet(1'b1, '1);
    fill_mode = 1;
    v4_packet(4'd5, PROTO_UDP, 8, 0);
    send_packet(1'b0, '0);
    fill_mode = 0;
    v4_packet(4'd15, 8'd1, 6, -1);
    send_packet(1'b1, {$urandom, $urandom});
    // ports land inside the IPv4 header
    v4_packet(4'd2, PROTO_TCP, 4, -1);
    send_packet(1'b0, {$urandom, $urandom});
    v4_packet(4'd0, PROTO_UDP, 0, -1);
    send_packet(1'b1, {$urandom, $urandom});
    v4_packet(4'd5, PROTO_TCP, 8, -1);
    cut(19);
    send_packet(1'b0, {$urandom, $urandom});
    v4_packet(4'd6, PROTO_UDP, 8, -1);
    cut(27);
    send_packet(1'b1, {$urandom, $urandom});
    junk_packet({VER_IPV4, 4'd5}, 1);
    send_packet(1'b0, {$urandom, $urandom});

    ext_plan.delete();
    fill_mode = 2;
    v6_packet(PROTO_TCP, 8, 16'hFFFF);
    send_packet(1'b1, '1);
    fill_mode = 1;
    v6_packet(PROTO_UDP, 8, -1);
    send_packet(1'b0, {$urandom, $urandom});
    fill_mode = 0;
    v6_packet(8'd58, 6, -1);
    send_packet(1'b1, {$urandom, $urandom});
    // zero payload length: chain is not walked
    ext_plan = '{NH_HOP_BY_HOP};
    v6_packet(PROTO_UDP, 8, 0);
    send_packet(1'b0, {$urandom, $urandom});
    ext_plan.delete();
    foreach (ext_types[j]) ext_plan.push_back(ext_types[j]);
    v6_packet(PROTO_TCP, 8, -1);
    send_packet(1'b1, {$urandom, $urandom});
    // chain runs past the payload end
    ext_plan = '{NH_ROUTING, NH_AH};
    v6_packet(PROTO_UDP, 8, 4);
    send_packet(1'b0, {$urandom, $urandom});
    ext_plan.delete();
    v6_packet(PROTO_TCP, 8, -1);
    cut(39);
    send_packet(1'b1, {$urandom, $urandom});
    ext_plan = '{NH_DEST_OPTS, NH_FRAGMENT};
    v6_packet(PROTO_UDP, 8, -1);
    cut(45);
    send_packet(1'b0, {$urandom, $urandom});
    ext_plan.delete();
    v6_packet(PROTO_UDP, 8, -1);
    cut(42);
    send_packet(1'b1, {$urandom, $urandom});
    junk_packet(8'h00, 1);
    send_packet(1'b0, {$urandom, $urandom});
    junk_packet(8'hF7, 20);
    send_packet(1'b1, {$urandom, $urandom});

    hold_go = 1;
    r_idx = 0;
    while (n_bytes < 2000 || r_idx < 48) begin
      calm = (r_idx >= 16 && r_idx < 30);
      ext_plan.delete();
      sel = $urandom_range(99);
      if (sel < 40) begin
        repeat ($urandom_range(3)) ext_plan.push_back(pick_ext());
        v6_packet(pick_upper(), $urandom_range(4, 24), -1);
      end else if (sel < 70) begin
        v4_packet(4'($urandom_range(5, 15)), pick_upper(), $urandom_range(4, 24), -1);
      end else if (sel < 75) begin
        v4_packet(4'($urandom_range(15)), pick_upper(), $urandom_range(24),
                  $urandom_range(65535));
      end else if (sel < 80) begin
        repeat ($urandom_range(3)) ext_plan.push_back(pick_ext());
        v6_packet(pick_upper(), $urandom_range(24), $urandom_range(65535));
      end else if (sel < 90) begin
        if ($urandom_range(1)) begin
          repeat ($urandom_range(3)) ext_plan.push_back(pick_ext());
          v6_packet(pick_upper(), $urandom_range(4, 24), -1);
        end else begin
          v4_packet(4'($urandom_range(5, 15)), pick_upper(), $urandom_range(4, 24), -1);
        end
        cut($urandom_range(1, pkt.size()));
      end else if (sel < 95) begin
        do v = 4'($urandom_range(15)); while (v == VER_IPV4 || v == VER_IPV6);
        first = rb();
        first[7:4] = v;
        junk_packet(first, $urandom_range(1, 40));
      end else begin
        junk_packet(rb(), $urandom_range(1, 60));
      end
      send_packet(1'($urandom_range(1)), {$urandom, $urandom});
      r_idx++;
    end
    calm = 0;

    @(posedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d packets (%0d bytes); results: %0d parsed, %0d bad version, %0d truncated.",
             n_pkts, n_bytes, n_ok, n_bad_ver, n_trunc);
    $display("Covered IPv4 and IPv6 with extension chains, short and cut packets, output hold-off.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("ip_flow_tuple_extractor_test: PASS");
    end else begin
      $display("ip_flow_tuple_extractor_test: FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("ip_flow_tuple_extractor_test: FAIL");
    $finish;
  end

endmodule
